// File: hw/rtl/assert_macros.svh
// assertion macros used by the top rtl file of the edit distance engine
// no dependencies; expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is held
`define EDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also evaluated during reset
`define EDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EDE_ASSERT(lbl, prop, msg)
`define EDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/ede_pkg.sv
// shared types and constants of the edit distance engine
// no dependencies
package ede_pkg;

  localparam int CHAR_W = 8;
  localparam int OP_W   = 2;
  localparam int DIST_W = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_CONSUME = 2'd2,
    OP_FINISH  = 2'd3
  } ede_op_t;

endpackage

// File: hw/rtl/ede_cell.sv
// one column cell of the systolic edit distance row
// depends on ede_pkg
module ede_cell
  import ede_pkg::*;
#(
  parameter int VW  = 7,
  parameter int IDX = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          clr,
  input  logic          wr,
  input  logic [VW-1:0] wr_idx,
  input  char_t         wr_byte,
  input  logic          wi_vld,
  input  char_t         wi_byte,
  input  logic [VW-1:0] wi_left,
  input  logic [VW-1:0] wi_diag,
  input  logic          ti_vld,
  input  logic [VW-1:0] ti_val,
  input  logic          ti_ovf,
  output logic          wo_vld,
  output char_t         wo_byte,
  output logic [VW-1:0] wo_left,
  output logic [VW-1:0] wo_diag,
  output logic          to_vld,
  output logic [VW-1:0] to_val,
  output logic          to_ovf
);

  logic          act_r;
  char_t         char_r;
  logic [VW-1:0] dp_r;
  logic          wo_vld_r;
  char_t         wo_byte_r;
  logic [VW-1:0] wo_left_r;
  logic [VW-1:0] wo_diag_r;
  logic          to_vld_r;
  logic [VW-1:0] to_val_r;
  logic          to_ovf_r;
  logic [VW-1:0] m_nxt;
  logic [VW-1:0] cell_nxt;
  logic          hit;

  assign hit = wr && (wr_idx == VW'(IDX - 1));

  // unit-cost recurrence: match takes the diagonal, else 1 + min of three
  always_comb begin
    m_nxt = (dp_r < wi_left) ? dp_r : wi_left;
    m_nxt = (m_nxt < wi_diag) ? m_nxt : wi_diag;
    if (char_r == wi_byte) begin
      cell_nxt = wi_diag;
    end else begin
      cell_nxt = m_nxt + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && clr)) begin
      act_r    <= 1'b0;
      dp_r     <= VW'(IDX);
      wo_vld_r <= 1'b0;
      to_vld_r <= 1'b0;
    end else if (en) begin
      if (hit) begin
        act_r <= 1'b1;
      end
      if (wi_vld && act_r) begin
        dp_r <= cell_nxt;
      end
      wo_vld_r <= wi_vld;
      to_vld_r <= ti_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hit) begin
        char_r <= wr_byte;
      end
      wo_byte_r <= wi_byte;
      wo_left_r <= cell_nxt;
      wo_diag_r <= dp_r;
      to_val_r  <= act_r ? dp_r : ti_val;
      to_ovf_r  <= ti_ovf;
    end
  end

  assign wo_vld  = wo_vld_r;
  assign wo_byte = wo_byte_r;
  assign wo_left = wo_left_r;
  assign wo_diag = wo_diag_r;
  assign to_vld  = to_vld_r;
  assign to_val  = to_val_r;
  assign to_ovf  = to_ovf_r;

endmodule

// File: hw/rtl/edit_distance_engine_top.sv
// Levenshtein edit distance engine: a row of MAX_LEN column cells fed by a small front end.
// Consume and finish words may follow back to back at the input; a consume word becomes a
// wavefront that walks the cell row one column per cycle unless the row is stalled, and a
// finish word becomes a token that trails the wavefronts and picks up the distance from the
// last loaded column on its way to the result register. Start and append words are held off
// (in_tready low) until the cell row has drained of the most recent consume or finish word.
// A stalled result stalls the whole row. No clearing pass is needed after reset; the second
// string store lives in the cells and is only read where a column was loaded since the last
// start. Distances above 127 are reported as 127; overflow flags a string longer than MAX_LEN.
// depends on ede_pkg, ede_cell and assert_macros.svh
`include "assert_macros.svh"
module edit_distance_engine_top
  import ede_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] op, [9:2] char_code, [15:10] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [6:0] distance, [7] overflow
);

  // column values and lengths all fit in 0..MAX_LEN
  localparam int LW = $clog2(MAX_LEN + 1);

  ede_op_t       op;
  char_t         in_char;
  logic          en;
  logic          busy;
  logic          acc;
  logic          acc_start;
  logic          acc_append;
  logic          acc_consume;
  logic          acc_finish;
  logic          wr;
  logic          wave_in;

  logic [LW-1:0] second_len_r;
  logic [LW-1:0] first_len_r;
  logic          ovf_r;
  logic [LW-1:0] drain_cnt_r;
  logic          out_vld_r;
  logic [DIST_W-1:0] out_dist_r;
  logic          out_ovf_r;
  logic [DIST_W-1:0] dist_nxt;

  // links between neighboring cells; link 0 is the front end
  logic          wv [0:MAX_LEN];
  char_t         wb [0:MAX_LEN];
  logic [LW-1:0] wl [0:MAX_LEN];
  logic [LW-1:0] wd [0:MAX_LEN];
  logic          tv [0:MAX_LEN];
  logic [LW-1:0] tval [0:MAX_LEN];
  logic          tovf [0:MAX_LEN];

  assign op      = ede_op_t'(in_tdata[OP_W-1:0]);
  assign in_char = in_tdata[OP_W +: CHAR_W];

  // the whole row advances only when the result register can take a word
  assign en   = !out_vld_r || out_tready;
  assign busy = (drain_cnt_r != '0);

  // start and append change column state, so they wait for in-flight tokens to leave
  always_comb begin
    in_tready = en;
    if (busy && (op == OP_START || op == OP_APPEND)) begin
      in_tready = 1'b0;
    end
  end

  assign acc         = in_tvalid && in_tready;
  assign acc_start   = acc && (op == OP_START);
  assign acc_append  = acc && (op == OP_APPEND);
  assign acc_consume = acc && (op == OP_CONSUME);
  assign acc_finish  = acc && (op == OP_FINISH);

  // appends load the next column until the first string begins or all MAX_LEN columns are loaded
  assign wr      = acc_append && (first_len_r == '0) && (second_len_r != LW'(MAX_LEN));
  assign wave_in = acc_consume && (first_len_r != LW'(MAX_LEN));

  // front end feeds column 0: new dp[0] on the left, old dp[0] on the diagonal
  assign wv[0]   = wave_in;
  assign wb[0]   = in_char;
  assign wl[0]   = first_len_r + LW'(1);
  assign wd[0]   = first_len_r;
  assign tv[0]   = acc_finish;
  assign tval[0] = first_len_r;
  assign tovf[0] = ovf_r;

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ede_cell #(
      .VW  (LW),
      .IDX (j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .clr     (acc_start),
      .wr      (wr),
      .wr_idx  (second_len_r),
      .wr_byte (in_char),
      .wi_vld  (wv[j-1]),
      .wi_byte (wb[j-1]),
      .wi_left (wl[j-1]),
      .wi_diag (wd[j-1]),
      .ti_vld  (tv[j-1]),
      .ti_val  (tval[j-1]),
      .ti_ovf  (tovf[j-1]),
      .wo_vld  (wv[j]),
      .wo_byte (wb[j]),
      .wo_left (wl[j]),
      .wo_diag (wd[j]),
      .to_vld  (tv[j]),
      .to_val  (tval[j]),
      .to_ovf  (tovf[j])
    );
  end

  // lengths, overflow flag and drain counter
  always_ff @(posedge clk) begin
    if (!rst_n || acc_start) begin
      second_len_r <= '0;
      first_len_r  <= '0;
      ovf_r        <= 1'b0;
      drain_cnt_r  <= '0;
    end else begin
      if (wr) begin
        second_len_r <= second_len_r + LW'(1);
      end
      if (acc_append && (first_len_r == '0) && (second_len_r == LW'(MAX_LEN))) begin
        ovf_r <= 1'b1;
      end
      if (wave_in) begin
        first_len_r <= first_len_r + LW'(1);
      end
      if (acc_consume && (first_len_r == LW'(MAX_LEN))) begin
        ovf_r <= 1'b1;
      end
      // each wavefront or token reloads the drain counter, which then counts down row advances
      if (acc_consume || acc_finish) begin
        drain_cnt_r <= LW'(MAX_LEN);
      end else if (en && busy) begin
        drain_cnt_r <= drain_cnt_r - LW'(1);
      end
    end
  end

  // clamp to the width of the distance field
  always_comb begin
    if (32'(tval[MAX_LEN]) > 32'd127) begin
      dist_nxt = DIST_W'(127);
    end else begin
      dist_nxt = DIST_W'(tval[MAX_LEN]);
    end
  end

  // result register parts the row from the output side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= tv[MAX_LEN];
    end
  end

  always_ff @(posedge clk) begin
    if (en && tv[MAX_LEN]) begin
      out_dist_r <= dist_nxt;
      out_ovf_r  <= tovf[MAX_LEN];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_ovf_r, out_dist_r};

  // a token or wavefront leaving the row must be covered by the drain counter
  `EDE_ASSERT(a_exit_counted, (tv[MAX_LEN] || wv[MAX_LEN]) |-> busy, "item left row while idle")
  `EDE_ASSERT(a_len_bound, (first_len_r <= LW'(MAX_LEN)) && (second_len_r <= LW'(MAX_LEN)), "length beyond MAX_LEN")
  `EDE_ASSERT(a_start_clears, acc_start |=> (first_len_r == '0) && (second_len_r == '0) && !ovf_r, "start did not clear")
  `EDE_ASSERT(a_append_late, (acc_append && (first_len_r != '0)) |=> $stable(second_len_r) && $stable(ovf_r), "late append took effect")

endmodule

// File: bench/testbench.sv
// self-checking bench for edit_distance_engine_top: directed table then random pair sequences
// predicts each distance with an in-bench levenshtein row update and checks every result word
// depends on ede_pkg and edit_distance_engine_top
module testbench;
  import ede_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_CAP     = 64;
  localparam int MAX_GAP     = 16;
  localparam int RANDOM_WORDS = 300;
  localparam int DRAIN_WAIT  = 2 * LEN_CAP + 40;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DIST_SAT    = 127;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  // one table row: a word repeated reps times, with an optional hand-written result
  typedef struct {
    ede_op_t           op;
    char_t             ch;
    int                reps;
    bit                typed;
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [1:0] op, [9:2] char_code, [15:10] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [6:0] distance, [7] overflow

  // predictor state for the pair being loaded
  char_t       second_bytes [LEN_CAP];
  int unsigned edit_row [LEN_CAP+1];
  int unsigned second_len;
  int unsigned first_len;
  bit          too_long;

  dist_result_t pending_distances [$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           rx_wait = 0;
  bit           rx_calm = 1'b0;
  bit           tx_calm = 1'b0;
  int           idle_cycles = 0;

  stim_row_t directed [26];

  always #5 clk = ~clk;

  edit_distance_engine_top #(
    .MAX_LEN(LEN_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // start word and reset leave the same state: empty strings, row j = j
  task automatic clear_pair();
    for (int j = 0; j <= LEN_CAP; j++) edit_row[j] = j;
    foreach (second_bytes[j]) second_bytes[j] = '0;
    second_len = 0;
    first_len  = 0;
    too_long   = 1'b0;
  endtask

  // advances the pair by one accepted word; a finish word yields a result
  task automatic advance_pair(input ede_op_t op, input char_t ch,
                              output bit emits, output dist_result_t res);
    int unsigned diag, above, dp_new, d;
    emits = 1'b0;
    res   = '0;
    case (op)
      OP_START: begin
        clear_pair();
      end
      OP_APPEND: begin
        // appends are dead once the first string has started
        if (first_len == 0) begin
          if (second_len >= LEN_CAP) begin
            too_long = 1'b1;
          end else begin
            second_bytes[second_len] = ch;
            second_len++;
          end
        end
      end
      OP_CONSUME: begin
        if (first_len >= LEN_CAP) begin
          too_long = 1'b1;
        end else begin
          diag = edit_row[0];
          first_len++;
          edit_row[0] = first_len;
          for (int j = 1; j <= second_len; j++) begin
            above = edit_row[j];
            if (second_bytes[j-1] == ch) begin
              dp_new = diag;
            end else begin
              dp_new = above < edit_row[j-1] ? above : edit_row[j-1];
              dp_new = 1 + (dp_new < diag ? dp_new : diag);
            end
            edit_row[j] = dp_new;
            diag = above;
          end
        end
      end
      default: begin
        d = edit_row[second_len];
        if (d > DIST_SAT) d = DIST_SAT;
        res.distance = d[DIST_W-1:0];
        res.overflow = too_long;
        emits = 1'b1;
      end
    endcase
  endtask

  // drives one input word after a random gap and waits for it to be taken
  task automatic send_word(input ede_op_t op, input char_t ch, input bit typed,
                           input dist_result_t typed_res);
    int gap;
    bit emits;
    dist_result_t res;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CHAR_W-OP_W){1'b0}}, ch, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_pair(op, ch, emits, res);
    if (emits) begin
      if (typed) res = typed_res;
      pending_distances = {pending_distances, res};
    end
    words_sent++;
  endtask

  // small alphabets make matches common so the diagonal path gets used
  function automatic char_t pick_char(input bit narrow, input char_t base);
    if (narrow) return base + char_t'($urandom_range(0, 3));
    return char_t'($urandom_range(0, 255));
  endfunction

  // result side: random stall after each taken word, check against the oldest expectation
  always @(posedge clk) begin
    dist_result_t want;
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (pending_distances.size() == 0) begin
        flag_mismatch($sformatf("result word 0x%02h with nothing expected", out_tdata));
      end else begin
        want = pending_distances.pop_front();
        if (out_tdata[DIST_W-1:0] !== want.distance)
          flag_mismatch($sformatf("distance %0d, expected %0d",
                                  out_tdata[DIST_W-1:0], want.distance));
        if (out_tdata[DIST_W] !== want.overflow)
          flag_mismatch($sformatf("overflow %0b, expected %0b",
                                  out_tdata[DIST_W], want.overflow));
      end
      // now and then switch between stalling and taking every word at once
      if ($urandom_range(0, 7) == 0) rx_calm <= ~rx_calm;
      w = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      out_tready <= (w == 0);
      rx_wait    <= w;
    end else if (!out_tready) begin
      if (rx_wait <= 1) out_tready <= 1'b1;
      rx_wait <= rx_wait - 1;
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("edit_distance_engine_top verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    dist_result_t typed_res;
    int n_second, n_first, n_finish, n_noise;
    bit narrow, big, skip_start, broken;
    char_t base;

    // directed rows: extremes, every op, the special cases of the pair
    directed = '{
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd0,  1'b0},  // result straight after reset
      '{OP_START,   8'hA5, 1,  1'b0, 7'd0,  1'b0},  // char ignored on start
      '{OP_APPEND,  8'h00, 1,  1'b0, 7'd0,  1'b0},
      '{OP_APPEND,  8'hFF, 1,  1'b0, 7'd0,  1'b0},
      '{OP_APPEND,  8'hAA, 1,  1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd3,  1'b0},  // empty first string
      '{OP_CONSUME, 8'h00, 1,  1'b0, 7'd0,  1'b0},
      '{OP_CONSUME, 8'h55, 1,  1'b0, 7'd0,  1'b0},
      '{OP_CONSUME, 8'hFF, 1,  1'b0, 7'd0,  1'b0},
      '{OP_APPEND,  8'h11, 1,  1'b0, 7'd0,  1'b0},  // append after consume is dropped
      '{OP_FINISH,  8'h00, 1,  1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'hFF, 1,  1'b0, 7'd0,  1'b0},  // finish leaves the pair alone
      '{OP_START,   8'h00, 1,  1'b0, 7'd0,  1'b0},
      '{OP_CONSUME, 8'h80, 1,  1'b0, 7'd0,  1'b0},
      '{OP_CONSUME, 8'h01, 1,  1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd2,  1'b0},  // empty second string
      '{OP_START,   8'hFF, 1,  1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd0,  1'b0},  // both strings empty
      '{OP_APPEND,  8'h5A, 65, 1'b0, 7'd0,  1'b0},  // second string one byte too long
      '{OP_CONSUME, 8'h5A, 64, 1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd0,  1'b1},  // full-length match
      '{OP_CONSUME, 8'h5A, 1,  1'b0, 7'd0,  1'b0},  // first string one byte too long
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd0,  1'b1},
      '{OP_START,   8'h00, 1,  1'b0, 7'd0,  1'b0},
      '{OP_CONSUME, 8'h33, 65, 1'b0, 7'd0,  1'b0},
      '{OP_FINISH,  8'h00, 1,  1'b1, 7'd64, 1'b1}   // largest distance
    };

    clear_pair();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) begin
      typed_res.distance = directed[r].distance;
      typed_res.overflow = directed[r].overflow;
      repeat (directed[r].reps)
        send_word(directed[r].op, directed[r].ch, directed[r].typed, typed_res);
    end

    typed_res = '0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any op, any byte
        n_noise = $urandom_range(1, 6);
        repeat (n_noise)
          send_word(ede_op_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
                    1'b0, typed_res);
      end else begin
        // a pair: start, second string, first string, finish
        narrow     = ($urandom_range(0, 2) != 0);
        base       = char_t'($urandom_range(0, 255));
        big        = ($urandom_range(0, 11) == 0);
        skip_start = ($urandom_range(0, 11) == 0);
        broken     = ($urandom_range(0, 7) == 0);
        n_second   = big ? $urandom_range(56, 68) : $urandom_range(0, 8);
        n_first    = big ? $urandom_range(56, 68) : $urandom_range(0, 8);
        n_finish   = $urandom_range(1, 2);
        if (!skip_start) send_word(OP_START, pick_char(1'b0, base), 1'b0, typed_res);
        repeat (n_second) send_word(OP_APPEND, pick_char(narrow, base), 1'b0, typed_res);
        repeat (n_first) begin
          send_word(OP_CONSUME, pick_char(narrow, base), 1'b0, typed_res);
          // broken pair: stray append in the middle of the first string
          if (broken && $urandom_range(0, 3) == 0)
            send_word(OP_APPEND, pick_char(narrow, base), 1'b0, typed_res);
        end
        repeat (n_finish) send_word(OP_FINISH, pick_char(1'b0, base), 1'b0, typed_res);
      end
    end

    // drop valid at the edge that took the last word
    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    // let any stray result word surface
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_distances.size() != 0) flag_mismatch("expected result never arrived");

    if (mismatches == 0) begin
      $display("edit_distance_engine_top verification clean");
    end else begin
      $display("edit_distance_engine_top verification failed");
    end
    $finish;
  end

endmodule
